@@ design/ptt_pkg.sv @@
// Shared types, constants and helpers for the periodic task timer table.
package ptt_pkg;

  // Table geometry
  localparam int NUM_TASKS   = 8;
  localparam int SLOT_W      = $clog2(NUM_TASKS);
  localparam int CNT_W       = $clog2(NUM_TASKS + 1);
  localparam int MAX_RESULTS = 8;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int HANDLE_W    = 3;

  // Reset values and limits
  localparam logic [31:0] DEFAULT_PERIOD = 32'd10000;
  localparam logic [7:0]  FIRE_NOW_LIMIT = 8'd128;
  localparam logic [15:0] TICK_RESET     = 16'd1000;

  // Input function codes
  localparam logic [2:0] FUNC_TICK       = 3'd0;
  localparam logic [2:0] FUNC_REGISTER   = 3'd1;
  localparam logic [2:0] FUNC_SET_PERIOD = 3'd2;
  localparam logic [2:0] FUNC_START      = 3'd3;
  localparam logic [2:0] FUNC_STOP       = 3'd4;
  localparam logic [2:0] FUNC_KILL       = 3'd5;
  localparam logic [2:0] FUNC_SERVICE    = 3'd6;
  localparam logic [2:0] FUNC_QUERY      = 3'd7;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_NOW    = 2'd1;
  localparam logic [1:0] KIND_DEFER  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  slot;
    logic [31:0] period_us;
    logic [7:0]  prio;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] task_id;
    logic [1:0] status;
    logic       running;
    logic       last;
  } out_word_t;

  // Ordered list update request
  typedef struct packed {
    logic       ins;
    logic       del;
    slot_t      slot;
    logic [7:0] prio;
  } list_cmd_t;

  // One request to a timer RAM
  typedef struct packed {
    logic        we;
    slot_t       waddr;
    logic [31:0] wdata;
    logic        re;
    slot_t       raddr;
  } ram_req_t;

  // Handle addresses an existing slot
  function automatic logic handle_ok(input logic [HANDLE_W-1:0] h);
    return 32'(h) < NUM_TASKS;
  endfunction

endpackage

@@ design/ptt_ram.sv @@
// Generic synchronous RAM, one write port and one registered read port.
module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ptt_order.sv @@
// Priority-ordered task list: a row of slot/priority cells with insert and remove.
module ptt_order (
  input  logic                     clk,
  input  logic                     rst,
  input  ptt_pkg::list_cmd_t       cmd,
  input  ptt_pkg::slot_t           rd_idx,
  output logic [ptt_pkg::CNT_W-1:0] count,
  output ptt_pkg::slot_t           rd_slot,
  output logic [7:0]               rd_prio
);

  ptt_pkg::slot_t slot_q [ptt_pkg::NUM_TASKS];
  logic [7:0]     prio_q [ptt_pkg::NUM_TASKS];
  ptt_pkg::slot_t slot_next [ptt_pkg::NUM_TASKS];
  logic [7:0]     prio_next [ptt_pkg::NUM_TASKS];
  logic [ptt_pkg::CNT_W-1:0]  count_next;
  logic [ptt_pkg::CNT_W-1:0]  ins_pos;
  logic [ptt_pkg::NUM_TASKS-1:0] le;
  logic [ptt_pkg::NUM_TASKS-1:0] match;
  logic hit;

  // Per-cell compares against the request
  always_comb begin
    for (int k = 0; k < ptt_pkg::NUM_TASKS; k++) begin
      le[k]    = (ptt_pkg::CNT_W'(k) < count) && (prio_q[k] <= cmd.prio);
      match[k] = (ptt_pkg::CNT_W'(k) < count) && (slot_q[k] == cmd.slot);
    end
  end

  // Next list contents
  always_comb begin
    slot_next  = slot_q;
    prio_next  = prio_q;
    count_next = count;
    ins_pos    = '0;
    hit        = 1'b0;
    // equal priorities stay behind earlier ones: position is the count of <= entries
    for (int k = 0; k < ptt_pkg::NUM_TASKS; k++) begin
      ins_pos = ins_pos + ptt_pkg::CNT_W'(le[k]);
    end
    if (cmd.ins) begin
      for (int k = 1; k < ptt_pkg::NUM_TASKS; k++) begin
        if (ptt_pkg::CNT_W'(k) > ins_pos) begin
          slot_next[k] = slot_q[k-1];
          prio_next[k] = prio_q[k-1];
        end
      end
      slot_next[ins_pos[ptt_pkg::SLOT_W-1:0]] = cmd.slot;
      prio_next[ins_pos[ptt_pkg::SLOT_W-1:0]] = cmd.prio;
      count_next = count + ptt_pkg::CNT_W'(1);
    end else if (cmd.del) begin
      // close the gap left by the matching cell
      for (int k = 0; k < ptt_pkg::NUM_TASKS - 1; k++) begin
        hit = hit | match[k];
        if (hit) begin
          slot_next[k] = slot_q[k+1];
          prio_next[k] = prio_q[k+1];
        end
      end
      if (|match) begin
        count_next = count - ptt_pkg::CNT_W'(1);
      end
    end
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Cell payload
  always_ff @(posedge clk) begin
    slot_q <= slot_next;
    prio_q <= prio_next;
  end

  assign rd_slot = slot_q[rd_idx];
  assign rd_prio = prio_q[rd_idx];

endmodule

@@ design/ptt_ctrl.sv @@
// Sequencer: decodes commands, scans the list on tick and service, owns flags and output.
module ptt_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ptt_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ptt_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [15:0]               cfg_data,
  output ptt_pkg::list_cmd_t        list_cmd,
  output ptt_pkg::slot_t            list_idx,
  input  logic [ptt_pkg::CNT_W-1:0] list_count,
  input  ptt_pkg::slot_t            list_slot,
  input  logic [7:0]                list_prio,
  output ptt_pkg::ram_req_t         per_req,
  input  logic [31:0]               per_rdata,
  output ptt_pkg::ram_req_t         rem_req,
  input  logic [31:0]               rem_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TREAD = 3'd1;
  localparam logic [2:0] S_TCALC = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]                 state;
  logic [15:0]                tick_len;
  logic [ptt_pkg::NUM_TASKS-1:0] in_use;
  logic [ptt_pkg::NUM_TASKS-1:0] asleep;
  logic [ptt_pkg::NUM_TASKS-1:0] pending;
  logic [ptt_pkg::CNT_W-1:0]  idx;
  logic [ptt_pkg::RES_W-1:0]  res_cnt;
  ptt_pkg::slot_t             cur_slot;
  logic                       cur_urgent;
  logic                       held_valid;
  ptt_pkg::out_word_t         held;

  ptt_pkg::slot_t     hslot;
  logic               hok;
  ptt_pkg::slot_t     free_slot;
  logic               free_found;
  logic               push_ok;
  logic               last_pos;
  logic               res_ok;
  logic               due;
  logic [31:0]        rem_new;
  logic               tick_want;
  logic               scan_want;
  logic               want;
  logic               stall;
  ptt_pkg::out_word_t new_word;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign list_idx  = idx[ptt_pkg::SLOT_W-1:0];

  // Handle check and lowest free slot
  assign hslot = ptt_pkg::slot_t'(in_data.slot);
  assign hok   = ptt_pkg::handle_ok(in_data.slot) && in_use[hslot];

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int k = ptt_pkg::NUM_TASKS - 1; k >= 0; k--) begin
      if (!in_use[k]) begin
        free_slot  = ptt_pkg::slot_t'(k);
        free_found = 1'b1;
      end
    end
  end

  // Scan bookkeeping
  assign push_ok  = !out_valid || out_ready;
  assign last_pos = ((idx + ptt_pkg::CNT_W'(1)) == list_count);
  assign res_ok   = res_cnt < ptt_pkg::RES_W'(ptt_pkg::MAX_RESULTS);

  // Remaining-time update for the entry read in S_TREAD
  assign due     = (rem_rdata <= {16'b0, tick_len});
  assign rem_new = due ? per_rdata : (rem_rdata - {16'b0, tick_len});

  // A new result is found; the held one must drain first
  assign tick_want = (state == S_TCALC) && due && cur_urgent && res_ok;
  assign scan_want = (state == S_SCAN) && !asleep[list_slot] && pending[list_slot] && res_ok;
  assign want      = tick_want || scan_want;
  assign stall     = want && held_valid && !push_ok;

  always_comb begin
    new_word         = '0;
    new_word.kind    = tick_want ? ptt_pkg::KIND_NOW : ptt_pkg::KIND_DEFER;
    new_word.task_id = tick_want ? 3'(cur_slot) : 3'(list_slot);
    new_word.status  = ptt_pkg::ST_OK;
  end

  // RAM and list requests
  always_comb begin
    per_req  = '0;
    rem_req  = '0;
    list_cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            ptt_pkg::FUNC_REGISTER: begin
              if (free_found) begin
                per_req.we    = 1'b1;
                per_req.waddr = free_slot;
                per_req.wdata = in_data.period_us;
                rem_req.we    = 1'b1;
                rem_req.waddr = free_slot;
                rem_req.wdata = in_data.period_us;
                list_cmd.ins  = 1'b1;
                list_cmd.slot = free_slot;
                list_cmd.prio = in_data.prio;
              end
            end
            ptt_pkg::FUNC_SET_PERIOD: begin
              if (hok) begin
                per_req.we    = 1'b1;
                per_req.waddr = hslot;
                per_req.wdata = in_data.period_us;
              end
            end
            ptt_pkg::FUNC_START: begin
              if (hok) begin
                per_req.re    = 1'b1;
                per_req.raddr = hslot;
              end
            end
            ptt_pkg::FUNC_KILL: begin
              if (hok) begin
                per_req.we    = 1'b1;
                per_req.waddr = hslot;
                per_req.wdata = ptt_pkg::DEFAULT_PERIOD;
                rem_req.we    = 1'b1;
                rem_req.waddr = hslot;
                rem_req.wdata = ptt_pkg::DEFAULT_PERIOD;
                list_cmd.del  = 1'b1;
                list_cmd.slot = hslot;
              end
            end
            default: ;
          endcase
        end
      end
      S_TREAD: begin
        if (!asleep[list_slot]) begin
          per_req.re    = 1'b1;
          per_req.raddr = list_slot;
          rem_req.re    = 1'b1;
          rem_req.raddr = list_slot;
        end
      end
      S_TCALC: begin
        if (!stall) begin
          rem_req.we    = 1'b1;
          rem_req.waddr = cur_slot;
          rem_req.wdata = rem_new;
        end
      end
      S_START: begin
        rem_req.we    = 1'b1;
        rem_req.waddr = cur_slot;
        rem_req.wdata = per_rdata;
      end
      default: ;
    endcase
  end

  // Control state, flags and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_len   <= ptt_pkg::TICK_RESET;
      in_use     <= '0;
      asleep     <= '1;
      pending    <= '0;
      idx        <= '0;
      res_cnt    <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tick_len <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // found result: push the held word, hold the new one
      if (want && !stall) begin
        if (held_valid) begin
          out_data  <= held;
          out_valid <= 1'b1;
        end
        held       <= new_word;
        held_valid <= 1'b1;
        res_cnt    <= res_cnt + ptt_pkg::RES_W'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            idx      <= '0;
            res_cnt  <= '0;
            cur_slot <= hslot;
            case (in_data.func)
              ptt_pkg::FUNC_TICK: begin
                state <= (list_count == '0) ? S_IDLE : S_TREAD;
              end
              ptt_pkg::FUNC_SERVICE: begin
                state <= (list_count == '0) ? S_IDLE : S_SCAN;
              end
              ptt_pkg::FUNC_REGISTER: begin
                held_valid   <= 1'b1;
                held         <= '0;
                held.kind    <= ptt_pkg::KIND_STATUS;
                if (free_found) begin
                  in_use[free_slot]  <= 1'b1;
                  asleep[free_slot]  <= 1'b1;
                  pending[free_slot] <= 1'b0;
                  held.task_id       <= 3'(free_slot);
                  held.status        <= ptt_pkg::ST_OK;
                end else begin
                  held.task_id <= 3'd0;
                  held.status  <= ptt_pkg::ST_FULL;
                end
                state <= S_FIN;
              end
              default: begin
                held_valid   <= 1'b1;
                held         <= '0;
                held.kind    <= ptt_pkg::KIND_STATUS;
                held.task_id <= in_data.slot;
                state        <= S_FIN;
                if (!hok) begin
                  held.status <= ptt_pkg::ST_BAD;
                end else begin
                  held.status  <= ptt_pkg::ST_OK;
                  held.running <= (in_data.func == ptt_pkg::FUNC_QUERY) && !asleep[hslot];
                  case (in_data.func)
                    ptt_pkg::FUNC_START: begin
                      pending[hslot] <= 1'b0;
                      asleep[hslot]  <= 1'b0;
                      state          <= S_START;
                    end
                    ptt_pkg::FUNC_STOP: begin
                      asleep[hslot] <= 1'b1;
                    end
                    ptt_pkg::FUNC_KILL: begin
                      in_use[hslot]  <= 1'b0;
                      asleep[hslot]  <= 1'b1;
                      pending[hslot] <= 1'b0;
                    end
                    default: ;
                  endcase
                end
              end
            endcase
          end
        end
        S_TREAD: begin
          cur_slot   <= list_slot;
          cur_urgent <= (list_prio < ptt_pkg::FIRE_NOW_LIMIT);
          if (!asleep[list_slot]) begin
            state <= S_TCALC;
          end else if (last_pos) begin
            state <= S_FIN;
          end else begin
            idx <= idx + ptt_pkg::CNT_W'(1);
          end
        end
        S_TCALC: begin
          if (!stall) begin
            if (due && !cur_urgent) begin
              pending[cur_slot] <= 1'b1;
            end
            if (last_pos) begin
              state <= S_FIN;
            end else begin
              idx   <= idx + ptt_pkg::CNT_W'(1);
              state <= S_TREAD;
            end
          end
        end
        S_START: begin
          state <= S_FIN;
        end
        S_SCAN: begin
          if (!stall) begin
            if (want) begin
              pending[list_slot] <= 1'b0;
            end
            if (last_pos) begin
              state <= S_FIN;
            end else begin
              idx <= idx + ptt_pkg::CNT_W'(1);
            end
          end
        end
        S_FIN: begin
          // final word of the item goes out marked last
          if (!held_valid) begin
            state <= S_IDLE;
          end else if (push_ok) begin
            out_data      <= held;
            out_data.last <= 1'b1;
            out_valid     <= 1'b1;
            held_valid    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/periodic_task_timer_table_top.sv @@
// Commands end in a state that sends the status word (start first reloads the remaining
// time); tick reads each listed task and updates each awake one; service visits each
// listed task; all are held up further only by output back-pressure. One item at a time:
// a new item is taken once the previous one has handed its last word to the output
// register. Periods and remaining times live in two 8-entry RAMs (read, write back);
// no clearing pass: synchronous reset resets flags, list count and output valid at once.
module periodic_task_timer_table_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ptt_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  ptt_pkg::list_cmd_t        list_cmd;
  ptt_pkg::slot_t            list_idx;
  logic [ptt_pkg::CNT_W-1:0] list_count;
  ptt_pkg::slot_t            list_slot;
  logic [7:0]                list_prio;
  ptt_pkg::ram_req_t         per_req;
  ptt_pkg::ram_req_t         rem_req;
  logic [31:0]               per_rdata;
  logic [31:0]               rem_rdata;

  // Sequencer
  ptt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .list_cmd   (list_cmd),
    .list_idx   (list_idx),
    .list_count (list_count),
    .list_slot  (list_slot),
    .list_prio  (list_prio),
    .per_req    (per_req),
    .per_rdata  (per_rdata),
    .rem_req    (rem_req),
    .rem_rdata  (rem_rdata)
  );

  // Priority-ordered list
  ptt_order u_order (
    .clk     (clk),
    .rst     (rst),
    .cmd     (list_cmd),
    .rd_idx  (list_idx),
    .count   (list_count),
    .rd_slot (list_slot),
    .rd_prio (list_prio)
  );

  // Reload periods
  ptt_ram #(.WIDTH(32), .DEPTH(ptt_pkg::NUM_TASKS)) u_per_ram (
    .clk   (clk),
    .we    (per_req.we),
    .waddr (per_req.waddr),
    .wdata (per_req.wdata),
    .re    (per_req.re),
    .raddr (per_req.raddr),
    .rdata (per_rdata)
  );

  // Remaining times
  ptt_ram #(.WIDTH(32), .DEPTH(ptt_pkg::NUM_TASKS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_req.we),
    .waddr (rem_req.waddr),
    .wdata (rem_req.wdata),
    .re    (rem_req.re),
    .raddr (rem_req.raddr),
    .rdata (rem_rdata)
  );

endmodule

@@ design/ptt_checker.sv @@
// Port-level checks for the timer table, bound to the top level.
module ptt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input ptt_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ptt_pkg::out_word_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // One item at a time: busy right after an accepted command
  // (tick and service on an empty list finish in the accept cycle)
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.func != ptt_pkg::FUNC_TICK) &&
      (in_data.func != ptt_pkg::FUNC_SERVICE) |=> !in_ready)
    else $error("second item taken while first in flight");

  // Fire words carry ok status and no running flag
  a_fire_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind != ptt_pkg::KIND_STATUS) |->
      (out_data.status == ptt_pkg::ST_OK) && !out_data.running)
    else $error("fire word with status or running set");

  // Running only on an ok status word
  a_running_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.running |->
      (out_data.kind == ptt_pkg::KIND_STATUS) && (out_data.status == ptt_pkg::ST_OK))
    else $error("running set on a non-ok or fire word");

  // Tick length writes are always taken
  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config word refused");

endmodule

bind periodic_task_timer_table_top ptt_checker u_ptt_checker (.*);

@@ tb/sv/testbench.sv @@
// Testbench for the periodic task timer table: directed and random commands, shadow table.
module testbench;

  localparam int          IDLE_LIMIT    = 5000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 400;
  localparam logic [7:0]  RESET_PRIO    = 8'd128;

  // Shadow copy of the timer table; predicts result words and checks them in order
  class timer_table_tracker;
    logic [31:0]         period_tab [ptt_pkg::NUM_TASKS];
    logic [31:0]         remain_tab [ptt_pkg::NUM_TASKS];
    logic [7:0]          prio_tab [ptt_pkg::NUM_TASKS];
    bit                  used [ptt_pkg::NUM_TASKS];
    bit                  sleeping [ptt_pkg::NUM_TASKS];
    bit                  marked [ptt_pkg::NUM_TASKS];
    ptt_pkg::slot_t      order [ptt_pkg::NUM_TASKS];
    int                  count;
    logic [15:0]         tick_len;
    ptt_pkg::out_word_t  due_words [$];
    int                  errors;

    function new();
      tick_len = ptt_pkg::TICK_RESET;
      count = 0;
      errors = 0;
      for (int i = 0; i < ptt_pkg::NUM_TASKS; i++) begin
        clear_slot(i);
        order[i] = '0;
      end
    endfunction

    function void clear_slot(int s);
      period_tab[s] = ptt_pkg::DEFAULT_PERIOD;
      remain_tab[s] = ptt_pkg::DEFAULT_PERIOD;
      prio_tab[s]   = RESET_PRIO;
      used[s]       = 1'b0;
      sleeping[s]   = 1'b1;
      marked[s]     = 1'b0;
    endfunction

    function ptt_pkg::out_word_t word_of(logic [1:0] kind, logic [2:0] id,
                                         logic [1:0] status, logic running);
      ptt_pkg::out_word_t w;
      w.kind    = kind;
      w.task_id = id;
      w.status  = status;
      w.running = running;
      w.last    = 1'b0;
      return w;
    endfunction

    // Apply one accepted input word to the table and queue the words it causes
    function void note_item(ptt_pkg::in_word_t w);
      ptt_pkg::out_word_t res [$];
      int                 s;
      int                 pos;
      int                 j;
      case (w.func)
        ptt_pkg::FUNC_TICK: begin
          for (int i = 0; i < count; i++) begin
            s = order[i];
            if (!sleeping[s]) begin
              if (remain_tab[s] > 32'(tick_len)) begin
                remain_tab[s] -= 32'(tick_len);
              end else begin
                remain_tab[s] = period_tab[s];
                if (prio_tab[s] < ptt_pkg::FIRE_NOW_LIMIT) begin
                  if (res.size() < ptt_pkg::MAX_RESULTS)
                    res.push_back(word_of(ptt_pkg::KIND_NOW, 3'(s), ptt_pkg::ST_OK, 1'b0));
                end else begin
                  marked[s] = 1'b1;
                end
              end
            end
          end
        end
        ptt_pkg::FUNC_REGISTER: begin
          s = 0;
          while (s < ptt_pkg::NUM_TASKS && used[s]) s++;
          if (s >= ptt_pkg::NUM_TASKS || count >= ptt_pkg::NUM_TASKS) begin
            res.push_back(word_of(ptt_pkg::KIND_STATUS, 3'd0, ptt_pkg::ST_FULL, 1'b0));
          end else begin
            period_tab[s] = w.period_us;
            remain_tab[s] = w.period_us;
            prio_tab[s]   = w.prio;
            used[s]       = 1'b1;
            sleeping[s]   = 1'b1;
            marked[s]     = 1'b0;
            // equal priorities keep registration order
            pos = 0;
            while (pos < count && prio_tab[order[pos]] <= prio_tab[s]) pos++;
            for (j = count; j > pos; j--) order[j] = order[j-1];
            order[pos] = ptt_pkg::slot_t'(s);
            count++;
            res.push_back(word_of(ptt_pkg::KIND_STATUS, 3'(s), ptt_pkg::ST_OK, 1'b0));
          end
        end
        ptt_pkg::FUNC_SERVICE: begin
          for (int i = 0; i < count && res.size() < ptt_pkg::MAX_RESULTS; i++) begin
            s = order[i];
            if (!sleeping[s] && marked[s]) begin
              marked[s] = 1'b0;
              res.push_back(word_of(ptt_pkg::KIND_DEFER, 3'(s), ptt_pkg::ST_OK, 1'b0));
            end
          end
        end
        default: begin
          s = w.slot;
          if (!(s < ptt_pkg::NUM_TASKS && used[s])) begin
            res.push_back(word_of(ptt_pkg::KIND_STATUS, w.slot, ptt_pkg::ST_BAD, 1'b0));
          end else begin
            case (w.func)
              ptt_pkg::FUNC_SET_PERIOD: period_tab[s] = w.period_us;
              ptt_pkg::FUNC_START: begin
                remain_tab[s] = period_tab[s];
                marked[s]     = 1'b0;
                sleeping[s]   = 1'b0;
              end
              ptt_pkg::FUNC_STOP: sleeping[s] = 1'b1;
              ptt_pkg::FUNC_KILL: begin
                j = 0;
                for (int i = 0; i < count; i++) begin
                  if (order[i] != s) begin
                    order[j] = order[i];
                    j++;
                  end
                end
                count = j;
                clear_slot(s);
              end
              default: ;
            endcase
            res.push_back(word_of(ptt_pkg::KIND_STATUS, w.slot, ptt_pkg::ST_OK,
                                  w.func == ptt_pkg::FUNC_QUERY && !sleeping[s]));
          end
        end
      endcase
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
      foreach (res[k]) due_words.push_back(res[k]);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // Compare one accepted output word with the oldest one due
    task check_word(ptt_pkg::out_word_t got);
      ptt_pkg::out_word_t want;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d id %0d status %0d",
                                  got.kind, got.task_id, got.status));
        return;
      end
      want = due_words.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.task_id !== want.task_id)
        report_mismatch($sformatf("task_id %0d, want %0d", got.task_id, want.task_id));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.running !== want.running)
        report_mismatch($sformatf("running %0d, want %0d", got.running, want.running));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  ptt_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ptt_pkg::out_word_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;

  timer_table_tracker tracker = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int idle_run       = 0;

  periodic_task_timer_table_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one word, with random gaps first; returns at the falling edge after acceptance
  task automatic send_item(ptt_pkg::in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(w);
    @(negedge clk);
  endtask

  task automatic send_cmd(logic [2:0] func, logic [2:0] slot, logic [31:0] period,
                          logic [7:0] prio);
    ptt_pkg::in_word_t w;
    w.func      = func;
    w.slot      = slot;
    w.period_us = period;
    w.prio      = prio;
    send_item(w);
  endtask

  // Periods mostly a few ticks long so tasks fire; sometimes zero or full range
  function automatic logic [31:0] pick_period();
    int unsigned base;
    base = (tracker.tick_len == 16'd0) ? 1 : int'(tracker.tick_len);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'd0;
      default: return base * $urandom_range(0, 4) + $urandom_range(0, base);
    endcase
  endfunction

  // Priorities clustered on a few values to get ties, plus the extremes
  function automatic logic [7:0] pick_prio();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'hFF;
      2: return ptt_pkg::FIRE_NOW_LIMIT - 8'd1;
      3: return ptt_pkg::FIRE_NOW_LIMIT;
      4, 5, 6: return 8'($urandom_range(0, 3) * 64);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly commands on live handles, some on random ones
  function automatic ptt_pkg::in_word_t pick_item();
    ptt_pkg::in_word_t w;
    int                r;
    r = $urandom_range(0, 99);
    if (r < 28)      w.func = ptt_pkg::FUNC_TICK;
    else if (r < 40) w.func = ptt_pkg::FUNC_REGISTER;
    else if (r < 50) w.func = ptt_pkg::FUNC_START;
    else if (r < 57) w.func = ptt_pkg::FUNC_STOP;
    else if (r < 64) w.func = ptt_pkg::FUNC_KILL;
    else if (r < 70) w.func = ptt_pkg::FUNC_SET_PERIOD;
    else if (r < 80) w.func = ptt_pkg::FUNC_SERVICE;
    else if (r < 90) w.func = ptt_pkg::FUNC_QUERY;
    else             w.func = 3'($urandom_range(0, 7));
    if (tracker.count > 0 && $urandom_range(0, 9) < 8)
      w.slot = tracker.order[$urandom_range(0, tracker.count - 1)];
    else
      w.slot = 3'($urandom_range(0, 7));
    w.period_us = pick_period();
    w.prio      = pick_prio();
    return w;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_item(pick_item());
  endtask

  // Let every due word arrive, then give the block time to finish silent work
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_tick(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.tick_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: check at the rising edge, pick ready at the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) tracker.check_word(out_data);
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("FAILURE");
    $finish;
  end

  // Main sequence
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // bad handles and empty table
    send_cmd(ptt_pkg::FUNC_QUERY,   3'd0, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_START,   3'd7, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_TICK,    3'd0, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_SERVICE, 3'd0, 32'd0, 8'd0);
    // fill the table, including priority ties, then one more
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd0, 32'd0,          8'd0);
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd0, 32'd1000,       8'hFF);
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd0, 32'hFFFF_FFFF,  ptt_pkg::FIRE_NOW_LIMIT - 8'd1);
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd0, 32'd2500,       ptt_pkg::FIRE_NOW_LIMIT);
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd0, 32'd1000,       8'd0);
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd0, 32'd500,        8'hFF);
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd0, 32'd3000,       8'd64);
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd0, 32'd1,          8'd200);
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd7, 32'd7,          8'd7);
    send_cmd(ptt_pkg::FUNC_START, 3'd0, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_START, 3'd1, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_START, 3'd3, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_START, 3'd4, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_START, 3'd5, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_QUERY, 3'd1, 32'd0, 8'd0);
    // immediate fires and pending marks
    send_cmd(ptt_pkg::FUNC_TICK, 3'd0, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_SET_PERIOD, 3'd0, 32'd5000, 8'd0);
    // stopped task keeps its mark but is not served
    send_cmd(ptt_pkg::FUNC_STOP, 3'd1, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_SERVICE, 3'd0, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_KILL, 3'd4, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_TICK, 3'd0, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_START, 3'd1, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_SERVICE, 3'd0, 32'd0, 8'd0);
    send_cmd(ptt_pkg::FUNC_REGISTER, 3'd0, 32'd10, 8'd0);

    // random phases over several tick lengths and flow-control patterns
    drain();
    write_tick(16'd1);
    run_random(70);

    drain();
    write_tick(16'hFFFF);
    send_idle_pct = 80;
    run_random(70);

    drain();
    write_tick(16'($urandom_range(2, 65534)));
    send_idle_pct  = 0;
    recv_stall_pct = 80;
    run_random(70);

    drain();
    write_tick(16'd0);
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    run_random(60);

    // long output hold-off so the block backs up into its input
    drain();
    write_tick(ptt_pkg::TICK_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    run_random(60);

    drain();
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
